/* design/adc_channel_scan_sequencer_assert.svh */
// Assertion macros for the ADC channel scan sequencer.
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_ASSERT_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define ACSS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after its antecedent.
`define ACSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/acss_pkg.sv */
// Types and constants of the ADC channel scan sequencer.
package acss_pkg;

    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned SETTLE_W = 8;

    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SETTLE_W-1:0] settle_t;

    // Scan phase of one channel slot
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE1 = 3'd1,
        PH_SETTLE2 = 3'd2,
        PH_START   = 3'd3,
        PH_CONVERT = 3'd4,
        PH_FINISH  = 3'd5
    } phase_t;

    // One tick of converter status and read request
    typedef struct packed {
        logic    conversion_done;
        sample_t sample;
        chan_t   read_channel;
    } scan_in_t;

    // Commands and read data issued for one tick
    typedef struct packed {
        logic    disable_valid;
        chan_t   disable_channel;
        logic    enable_valid;
        chan_t   enable_channel;
        logic    start_conversion;
        logic    captured;
        logic    all_scanned;
        sample_t read_value;
    } scan_out_t;

    localparam settle_t SETTLE_RESET = 8'd1;

endpackage

/* design/adc_channel_scan_sequencer.sv */
// Round-robin ADC channel scan sequencer: every input transaction is one tick. Each
// channel slot runs disable previous channel, settle, enable current channel, settle,
// start conversion, wait for done and store the sample, then advance (a wrap sets the
// sticky all_scanned flag). Every tick also returns the stored sample of read_channel,
// including one captured in the same tick; an index past the last channel reads 0.
// One transaction is taken per clock cycle while in_stall is low; each passes an input
// register and then a result register, where the result is held until it is taken.
// The combinational next-state logic between the registers sets the rate;
// in_stall rises only while both registers are full and the result is stalled.
// cfg_wr_en writes settle_ticks (0 acts as 1); write it only while no transaction is
// in flight.
module adc_channel_scan_sequencer #(
    parameter int unsigned NUM_CHANNELS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  acss_pkg::settle_t   cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  acss_pkg::scan_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output acss_pkg::scan_out_t out_data
);

    `include "adc_channel_scan_sequencer_assert.svh"

    localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    acss_pkg::settle_t   settle_ticks_reg;
    logic                in_valid_reg;
    acss_pkg::scan_in_t  in_data_reg;
    logic                out_valid_reg;
    acss_pkg::scan_out_t out_data_reg;

    acss_pkg::phase_t    phase_reg, phase_next;
    logic [CH_W-1:0]     cur_reg, cur_next;
    acss_pkg::settle_t   count_reg, count_next;
    logic                ready_reg, ready_next;
    acss_pkg::sample_t   store_reg [NUM_CHANNELS];

    acss_pkg::scan_out_t result;
    acss_pkg::settle_t   settle_load;
    acss_pkg::settle_t   count_dec;
    logic                store_we;
    logic                move;
    logic                accept;
    logic                rd_ok;
    logic [CH_W-1:0]     rd_idx;
    logic                settling;
    logic [3:0]          out_cmds;

    // Handshake: the input register drains into the result register
    assign move     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !move;
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign settle_load = (settle_ticks_reg == '0) ? acss_pkg::SETTLE_RESET : settle_ticks_reg;
    assign count_dec   = count_reg - acss_pkg::settle_t'(1);

    // Hold the settle length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= acss_pkg::SETTLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            settle_ticks_reg <= cfg_wr_data;
        end
    end

    // Capture an accepted transaction; drop it once it moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
    end

    // Next phase and the commands of this tick
    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        ready_next = ready_reg;
        store_we   = 1'b0;
        result     = '0;

        unique case (phase_reg)
            acss_pkg::PH_SETTLE1:
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    result.enable_valid   = 1'b1;
                    result.enable_channel = acss_pkg::chan_t'(cur_reg);
                    count_next = settle_load;
                    phase_next = acss_pkg::PH_SETTLE2;
                end
            end
            acss_pkg::PH_SETTLE2:
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    phase_next = acss_pkg::PH_START;
                end
            end
            acss_pkg::PH_START:
            begin
                result.start_conversion = 1'b1;
                phase_next = acss_pkg::PH_CONVERT;
            end
            acss_pkg::PH_CONVERT:
            begin
                if (in_data_reg.conversion_done)
                begin
                    store_we        = 1'b1;
                    result.captured = 1'b1;
                    phase_next      = acss_pkg::PH_FINISH;
                end
            end
            acss_pkg::PH_FINISH:
            begin
                if (cur_reg == LAST_CH)
                begin
                    cur_next   = '0;
                    ready_next = 1'b1;
                end
                else
                begin
                    cur_next = cur_reg + CH_W'(1);
                end
                phase_next = acss_pkg::PH_IDLE;
            end
            default:
            begin
                // idle, and any unused phase code
                result.disable_valid   = 1'b1;
                result.disable_channel = (cur_reg == '0) ? acss_pkg::chan_t'(LAST_CH)
                                                         : acss_pkg::chan_t'(cur_reg - CH_W'(1));
                count_next = settle_load;
                phase_next = acss_pkg::PH_SETTLE1;
            end
        endcase

        result.all_scanned = ready_next;

        // Read the store, bypassing a sample written this tick
        if (!rd_ok)
        begin
            result.read_value = '0;
        end
        else if (store_we && (rd_idx == cur_reg))
        begin
            result.read_value = in_data_reg.sample;
        end
        else
        begin
            result.read_value = store_reg[rd_idx];
        end
    end

    assign rd_ok  = {1'b0, in_data_reg.read_channel} < 5'(NUM_CHANNELS);
    assign rd_idx = in_data_reg.read_channel[CH_W-1:0];

    // Advance the scan state once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= acss_pkg::PH_IDLE;
            cur_reg   <= '0;
            count_reg <= '0;
            ready_reg <= 1'b0;
        end
        else if (move)
        begin
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            ready_reg <= ready_next;
        end
    end

    // Store captured samples per channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (move && store_we)
        begin
            store_reg[cur_reg] <= in_data_reg.sample;
        end
    end

    // Hold the result until the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= result;
        end
    end

    // Group the settle phases and the issued commands for the checks below
    assign settling = (phase_reg == acss_pkg::PH_SETTLE1) || (phase_reg == acss_pkg::PH_SETTLE2);
    assign out_cmds = {out_data_reg.disable_valid, out_data_reg.enable_valid,
                       out_data_reg.start_conversion, out_data_reg.captured};

    `ACSS_ASSERT_ALWAYS(a_cur_in_range, cur_reg <= LAST_CH, "current channel out of range")
    `ACSS_ASSERT_ALWAYS(a_settle_nonzero, !(settling && count_reg == '0), "settle counter zero")
    `ACSS_ASSERT_ALWAYS(a_one_command, !out_valid_reg || $onehot0(out_cmds), "commands overlap")
    `ACSS_ASSERT_NEXT(a_ready_sticky, ready_reg, ready_reg, "all-scanned flag cleared")
    `ACSS_ASSERT_NEXT(a_state_holds, !move, $stable({phase_reg, cur_reg}), "state not held")

endmodule

/* test/adc_channel_scan_sequencer_checker.sv */
// Checker for the ADC channel scan sequencer: predicts each tick and compares results.
`timescale 1ns / 100ps

module adc_channel_scan_sequencer_checker #(
    parameter int unsigned NUM_CHANNELS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  acss_pkg::settle_t   cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  acss_pkg::scan_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  acss_pkg::scan_out_t out_data,
    output int unsigned         pending_count,
    output int unsigned         mismatch_count
);

    // Predicted sequencer state
    acss_pkg::phase_t    slot_phase;
    acss_pkg::chan_t     scan_chan;
    acss_pkg::settle_t   settle_left;
    acss_pkg::settle_t   settle_cfg;
    acss_pkg::sample_t   stored [NUM_CHANNELS];
    logic                sweep_done;

    acss_pkg::scan_out_t expected_ticks [$];
    int unsigned         error_total;

    // A zero settle setting behaves as one tick
    function automatic acss_pkg::settle_t settle_reload();
        return (settle_cfg == '0) ? acss_pkg::settle_t'(1) : settle_cfg;
    endfunction

    // Advance the predicted sequencer by one tick and return its outputs
    function automatic acss_pkg::scan_out_t advance_scan(acss_pkg::scan_in_t tick);
        acss_pkg::scan_out_t res;
        res = '0;
        case (slot_phase)
            acss_pkg::PH_SETTLE1:
            begin
                settle_left = settle_left - 1'b1;
                if (settle_left == '0)
                begin
                    res.enable_valid   = 1'b1;
                    res.enable_channel = scan_chan;
                    settle_left        = settle_reload();
                    slot_phase         = acss_pkg::PH_SETTLE2;
                end
            end
            acss_pkg::PH_SETTLE2:
            begin
                settle_left = settle_left - 1'b1;
                if (settle_left == '0)
                    slot_phase = acss_pkg::PH_START;
            end
            acss_pkg::PH_START:
            begin
                res.start_conversion = 1'b1;
                slot_phase           = acss_pkg::PH_CONVERT;
            end
            acss_pkg::PH_CONVERT:
            begin
                // done is only looked at while a conversion is pending
                if (tick.conversion_done)
                begin
                    stored[scan_chan] = tick.sample;
                    res.captured      = 1'b1;
                    slot_phase        = acss_pkg::PH_FINISH;
                end
            end
            acss_pkg::PH_FINISH:
            begin
                if (scan_chan == acss_pkg::chan_t'(NUM_CHANNELS - 1))
                begin
                    scan_chan  = '0;
                    sweep_done = 1'b1;
                end
                else
                    scan_chan = scan_chan + 1'b1;
                slot_phase = acss_pkg::PH_IDLE;
            end
            default:
            begin
                // disable the previous channel, wrapping from 0 to the last one
                res.disable_valid   = 1'b1;
                res.disable_channel = (scan_chan == '0) ? acss_pkg::chan_t'(NUM_CHANNELS - 1)
                                                        : scan_chan - 1'b1;
                settle_left         = settle_reload();
                slot_phase          = acss_pkg::PH_SETTLE1;
            end
        endcase
        res.all_scanned = sweep_done;
        // read after this tick's capture; out-of-range reads give zero
        res.read_value  = (tick.read_channel < NUM_CHANNELS) ? stored[tick.read_channel] : '0;
        return res;
    endfunction

    // Report one field that differs
    task automatic check_field(input string field,
                               input logic [acss_pkg::SAMPLE_W-1:0] want_v,
                               input logic [acss_pkg::SAMPLE_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            error_total++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endtask

    // Track configuration, predict accepted transactions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        acss_pkg::scan_out_t want;
        if (!rst_n)
        begin
            slot_phase  = acss_pkg::PH_IDLE;
            scan_chan   = '0;
            settle_left = '0;
            settle_cfg  = acss_pkg::SETTLE_RESET;
            sweep_done  = 1'b0;
            foreach (stored[i])
                stored[i] = '0;
            expected_ticks.delete();
            error_total = 0;
            pending_count  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                settle_cfg = cfg_wr_data;
            if (in_valid && !in_stall)
                expected_ticks.push_back(advance_scan(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                begin
                    error_total++;
                    $display("%0t: result expected none, got %h", $time, out_data);
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    check_field("disable_valid", want.disable_valid, out_data.disable_valid);
                    check_field("disable_channel", want.disable_channel,
                                out_data.disable_channel);
                    check_field("enable_valid", want.enable_valid, out_data.enable_valid);
                    check_field("enable_channel", want.enable_channel,
                                out_data.enable_channel);
                    check_field("start_conversion", want.start_conversion,
                                out_data.start_conversion);
                    check_field("captured", want.captured, out_data.captured);
                    check_field("all_scanned", want.all_scanned, out_data.all_scanned);
                    check_field("read_value", want.read_value, out_data.read_value);
                end
            end
            pending_count  <= expected_ticks.size();
            mismatch_count <= error_total;
        end
    end

endmodule

/* test/tb_adc_channel_scan_sequencer.sv */
// Testbench top for the ADC channel scan sequencer: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_adc_channel_scan_sequencer;

    localparam int unsigned NUM_CHANNELS = 12;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    acss_pkg::settle_t   cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    acss_pkg::scan_in_t  in_data;
    logic                out_valid;
    logic                out_stall = 1'b0;
    acss_pkg::scan_out_t out_data;
    int unsigned         pending_count;
    int unsigned         mismatch_count;

    stall_mode_t stall_mode = STALL_NONE;
    int unsigned stall_left = 0;

    adc_channel_scan_sequencer #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    adc_channel_scan_sequencer_checker #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .pending_count (pending_count),
        .mismatch_count(mismatch_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver stall: switch to a random stall pattern whenever stall_left runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= 63;
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (stall_left % 3 == 0);
        endcase
    end

    // Hold one transaction until it is accepted
    task automatic send_tick(input acss_pkg::scan_in_t tick);
        in_valid <= 1'b1;
        in_data  <= tick;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Wait until every predicted result has come back, then let the pipeline settle
    task automatic wait_drained();
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settle(input acss_pkg::settle_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic acss_pkg::scan_in_t random_tick();
        acss_pkg::scan_in_t tick;
        tick.conversion_done = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 7))
            0:       tick.sample = '0;
            1:       tick.sample = '1;
            default: tick.sample = acss_pkg::sample_t'($urandom_range(0, 4095));
        endcase
        tick.read_channel = acss_pkg::chan_t'($urandom_range(0, 15));
        return tick;
    endfunction

    // Send random ticks in bursts with random gaps, some with no gap at all
    task automatic run_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_tick(random_tick());
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (sent < count && gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    // Directed ticks at the reset settle value: done flags outside a conversion,
    // out-of-range reads, sample extremes and a read of the channel captured that tick
    task automatic run_directed();
        acss_pkg::scan_in_t tick;
        acss_pkg::chan_t    read_order [8];
        read_order = '{4'd15, 4'd12, 4'd11, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1};
        for (int i = 0; i < 24; i++)
        begin
            tick.conversion_done = (i != 4) && (i != 10);
            tick.sample          = (i % 2 == 1) ? acss_pkg::sample_t'('1)
                                                : acss_pkg::sample_t'('0);
            tick.read_channel    = read_order[i % 8];
            send_tick(tick);
        end
        in_valid <= 1'b0;
    endtask

    // Stimulus and verdict
    initial
    begin
        acss_pkg::settle_t settle_plan [6];
        int                plan_len [6];
        settle_plan = '{8'd0, 8'd2, 8'd255, 8'd1, 8'd0, 8'd0};
        plan_len    = '{120, 120, 600, 150, 150, 150};
        settle_plan[4] = acss_pkg::settle_t'($urandom_range(1, 8));
        settle_plan[5] = acss_pkg::settle_t'($urandom_range(1, 255));
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            write_settle(settle_plan[p]);
            run_random((p == 5) ? 60 : plan_len[p]);
        end
        wait_drained();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/acss_pkg.sv
design/adc_channel_scan_sequencer.sv
test/adc_channel_scan_sequencer_checker.sv
test/tb_adc_channel_scan_sequencer.sv
